// File: rtl/core/vmp_pkg.sv
`default_nettype none

package vmp_pkg;

   localparam int ADDR_W      = 24;
   localparam int WAIT_W      = 24;
   localparam int DEB_W       = 16;
   localparam int PWM_W       = 8;
   localparam int BLINK_W     = 16;
   localparam int TRACK_SEL_W = 2;
   localparam int MODE_W      = 2;
   localparam int MAX_TRACKS  = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRACK0_START  = 3'd0,
      CSR_TRACK0_LENGTH = 3'd1,
      CSR_TRACK1_START  = 3'd2,
      CSR_TRACK1_LENGTH = 3'd3,
      CSR_TRACK2_START  = 3'd4,
      CSR_TRACK2_LENGTH = 3'd5,
      CSR_WAIT_TICKS    = 3'd6,
      CSR_DEBOUNCE      = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_STOPPED = 3'b001,
      MODE_RUNNING = 3'b010,
      MODE_WAITING = 3'b100
   } mode_type;

   localparam logic [MODE_W-1:0] MODE_CODE_STOPPED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CODE_RUNNING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CODE_WAITING = 2'd2;

   localparam logic [ADDR_W-1:0] TRACK_START_RESET [MAX_TRACKS] =
      '{24'd0, 24'd380250, 24'd696041};
   localparam logic [ADDR_W-1:0] TRACK_LENGTH_RESET [MAX_TRACKS] =
      '{24'd380250, 24'd315791, 24'd186131};
   localparam logic [WAIT_W-1:0] WAIT_TICKS_RESET = 24'd120000;
   localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 16'd4000;

   typedef struct packed {
      logic [WAIT_W-1:0] wait_ticks;
      logic [DEB_W-1:0]  debounce_ticks;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
   } seek_type;

   typedef struct packed {
      logic              start_pressed;
      logic              next_pressed;
      logic [PWM_W-1:0]  sample_data;
   } item_type;

   typedef struct packed {
      logic [PWM_W-1:0]  pwm_duty;
      logic              ptt_on;
      logic              busy_led;
      logic              blink_led;
      logic [ADDR_W-1:0] read_address;
      logic [MODE_W-1:0] mode;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/vmp_csr.sv
`default_nettype none

module vmp_csr
   import vmp_pkg::*;
#(
   parameter int TRACK_COUNT = 3
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic [TRACK_SEL_W-1:0] track_sel,
   output cfg_type                     cfg,
   output seek_type                    seek
);

   logic [ADDR_W-1:0] start_ff  [TRACK_COUNT];
   logic [ADDR_W-1:0] length_ff [TRACK_COUNT];
   logic [WAIT_W-1:0] wait_ff;
   logic [DEB_W-1:0]  debounce_ff;

   for (genvar t = 0; t < TRACK_COUNT; t++) begin : g_track
      always_ff @(posedge clock) begin
         if (reset) begin
            start_ff[t]  <= TRACK_START_RESET[t];
            length_ff[t] <= TRACK_LENGTH_RESET[t];
         end else if (csr_valid) begin
            if (csr_index == CSR_INDEX_W'(2 * t)) begin
               start_ff[t] <= csr_data[ADDR_W-1:0];
            end
            if (csr_index == CSR_INDEX_W'(2 * t + 1)) begin
               length_ff[t] <= csr_data[ADDR_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff     <= WAIT_TICKS_RESET;
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_WAIT_TICKS) begin
            wait_ff <= csr_data[WAIT_W-1:0];
         end
         if (csr_index == CSR_DEBOUNCE) begin
            debounce_ff <= csr_data[DEB_W-1:0];
         end
      end
   end

   // A selection beyond the stored tracks falls back to track 0.
   always_comb begin
      seek.start  = start_ff[0];
      seek.length = length_ff[0];
      for (int i = 1; i < TRACK_COUNT; i++) begin
         if (track_sel == TRACK_SEL_W'(i)) begin
            seek.start  = start_ff[i];
            seek.length = length_ff[i];
         end
      end
   end

   assign cfg.wait_ticks     = wait_ff;
   assign cfg.debounce_ticks = debounce_ff;

endmodule

`default_nettype wire

// File: rtl/core/vmp_engine.sv
`default_nettype none

module vmp_engine
   import vmp_pkg::*;
#(
   parameter int TRACK_COUNT = 3
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire item_type               item,
   input  wire cfg_type                cfg,
   input  wire seek_type               seek,
   output logic [TRACK_SEL_W-1:0]      track_sel,
   output result_type                  result
);

   mode_type               mode_ff, mode_in;
   logic [TRACK_SEL_W-1:0] track_ff, track_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [ADDR_W-1:0]      left_ff, left_in;
   logic [ADDR_W-1:0]      left_dec;
   logic [WAIT_W-1:0]      wait_ff, wait_in;
   logic [DEB_W-1:0]       db_start_ff, db_start_in;
   logic [DEB_W-1:0]       db_next_ff, db_next_in;
   logic                   lock_start_ff, lock_start_in;
   logic                   lock_next_ff, lock_next_in;
   logic                   phase_ff, phase_in;
   logic [BLINK_W-1:0]     blink_ff, blink_in;
   logic [PWM_W-1:0]       pwm_ff, pwm_in;
   logic                   playing_ff, playing_in;
   logic [TRACK_SEL_W:0]   track_inc;

   assign track_inc = {1'b0, track_ff} + (TRACK_SEL_W + 1)'(1);
   assign left_dec  = (left_ff != '0) ? left_ff - ADDR_W'(1) : left_ff;

   always_comb begin
      mode_in       = mode_ff;
      track_in      = track_ff;
      addr_in       = addr_ff;
      left_in       = left_ff;
      wait_in       = wait_ff;
      db_start_in   = db_start_ff;
      db_next_in    = db_next_ff;
      lock_start_in = lock_start_ff;
      lock_next_in  = lock_next_ff;
      pwm_in        = pwm_ff;
      playing_in    = playing_ff;
      blink_in      = blink_ff + BLINK_W'(1);
      phase_in      = !phase_ff;

      if (phase_ff) begin
         unique case (mode_ff)
            MODE_RUNNING: begin
               pwm_in  = item.sample_data;
               addr_in = addr_ff + ADDR_W'(1);
               left_in = left_dec;
               if (left_dec == '0) begin
                  addr_in    = seek.start;
                  left_in    = seek.length;
                  mode_in    = MODE_WAITING;
                  wait_in    = cfg.wait_ticks;
                  playing_in = 1'b0;
               end
            end
            MODE_WAITING: begin
               if (wait_ff <= WAIT_W'(1)) begin
                  wait_in    = '0;
                  mode_in    = MODE_RUNNING;
                  playing_in = 1'b1;
               end else begin
                  wait_in = wait_ff - WAIT_W'(1);
               end
            end
            MODE_STOPPED: begin
            end
            default: begin
            end
         endcase
         if (db_start_ff != '0) begin
            db_start_in = db_start_ff - DEB_W'(1);
         end
         if (db_next_ff != '0) begin
            db_next_in = db_next_ff - DEB_W'(1);
         end
      end

      if (db_start_in == '0) begin
         if (item.start_pressed) begin
            if (!lock_start_ff) begin
               db_start_in   = cfg.debounce_ticks;
               lock_start_in = 1'b1;
               if (mode_in == MODE_STOPPED) begin
                  playing_in = 1'b1;
                  mode_in    = MODE_RUNNING;
                  addr_in    = seek.start;
                  left_in    = seek.length;
               end else begin
                  mode_in    = MODE_STOPPED;
                  playing_in = 1'b0;
               end
            end
         end else begin
            lock_start_in = 1'b0;
         end
      end

      if (db_next_in == '0) begin
         if (item.next_pressed) begin
            if (!lock_next_ff) begin
               db_next_in   = cfg.debounce_ticks;
               lock_next_in = 1'b1;
               if (track_inc >= (TRACK_SEL_W + 1)'(TRACK_COUNT)) begin
                  track_in = '0;
               end else begin
                  track_in = track_inc[TRACK_SEL_W-1:0];
               end
            end
         end else begin
            lock_next_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_STOPPED;
         track_ff      <= '0;
         addr_ff       <= TRACK_START_RESET[0];
         left_ff       <= TRACK_LENGTH_RESET[0];
         wait_ff       <= '0;
         db_start_ff   <= '0;
         db_next_ff    <= '0;
         lock_start_ff <= 1'b0;
         lock_next_ff  <= 1'b0;
         phase_ff      <= 1'b0;
         blink_ff      <= '0;
         pwm_ff        <= '0;
         playing_ff    <= 1'b0;
      end else if (advance) begin
         mode_ff       <= mode_in;
         track_ff      <= track_in;
         addr_ff       <= addr_in;
         left_ff       <= left_in;
         wait_ff       <= wait_in;
         db_start_ff   <= db_start_in;
         db_next_ff    <= db_next_in;
         lock_start_ff <= lock_start_in;
         lock_next_ff  <= lock_next_in;
         phase_ff      <= phase_in;
         blink_ff      <= blink_in;
         pwm_ff        <= pwm_in;
         playing_ff    <= playing_in;
      end
   end

   assign track_sel = track_ff;

   always_comb begin
      result.pwm_duty     = pwm_in;
      result.ptt_on       = playing_in;
      result.busy_led     = playing_in;
      result.blink_led    = blink_in[BLINK_W-1];
      result.read_address = addr_in;
      unique case (mode_in)
         MODE_STOPPED: result.mode = MODE_CODE_STOPPED;
         MODE_RUNNING: result.mode = MODE_CODE_RUNNING;
         MODE_WAITING: result.mode = MODE_CODE_WAITING;
         default:      result.mode = MODE_CODE_STOPPED;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/voice_message_playback_controller_core.sv
`default_nettype none

// Voice message playback controller. Each request transaction is one timer tick carrying
// the two button levels and the memory byte at the read address of the previous response;
// each tick yields exactly one response transaction with the PWM value, PTT, LEDs, the next
// read address and the mode. A tick is held in an input register, evaluated combinationally
// against the controller state and placed in an output register, so one tick is taken per
// clock unless the response side stalls; the output register lets a new tick enter while
// the previous response is still stalled. The user must write track start and length,
// wait period and debounce time via the csr port only with no tick in flight; not enforced.
module voice_message_playback_controller_core
   import vmp_pkg::*;
#(
   parameter int TRACK_COUNT = 3
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_start_pressed,
   input  wire logic                   req_next_pressed,
   input  wire logic [PWM_W-1:0]       req_sample_data,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [PWM_W-1:0]            rsp_pwm_duty,
   output logic                        rsp_ptt_on,
   output logic                        rsp_busy_led,
   output logic                        rsp_blink_led,
   output logic [ADDR_W-1:0]           rsp_read_address,
   output logic [MODE_W-1:0]           rsp_mode,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   item_type               item_ff;
   logic                   item_valid_ff;
   result_type             result_ff;
   logic                   result_valid_ff;
   result_type             result;
   cfg_type                cfg;
   seek_type               seek;
   logic [TRACK_SEL_W-1:0] track_sel;
   logic                   advance;
   logic                   accept;

   assign advance   = item_valid_ff && (!result_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            result_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            result_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.start_pressed <= req_start_pressed;
         item_ff.next_pressed  <= req_next_pressed;
         item_ff.sample_data   <= req_sample_data;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   vmp_csr #(
      .TRACK_COUNT (TRACK_COUNT)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .track_sel (track_sel),
      .cfg       (cfg),
      .seek      (seek)
   );

   vmp_engine #(
      .TRACK_COUNT (TRACK_COUNT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item_ff),
      .cfg       (cfg),
      .seek      (seek),
      .track_sel (track_sel),
      .result    (result)
   );

   assign rsp_valid        = result_valid_ff;
   assign rsp_pwm_duty     = result_ff.pwm_duty;
   assign rsp_ptt_on       = result_ff.ptt_on;
   assign rsp_busy_led     = result_ff.busy_led;
   assign rsp_blink_led    = result_ff.blink_led;
   assign rsp_read_address = result_ff.read_address;
   assign rsp_mode         = result_ff.mode;

endmodule

`default_nettype wire
